@@ hw/rtl/kcal_pkg.sv @@
package kcal_pkg;

  // Lock modes, as reported on the mode field
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_COUNT  = 3'd1,
    MODE_ARMED  = 3'd2,
    MODE_VERIFY = 3'd3,
    MODE_NEW    = 3'd4
  } mode_e;

  // Per-item event codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_CLEAR   = 3'd2,
    EV_ACCEPT  = 3'd3,
    EV_REJECT  = 3'd4,
    EV_ARMED   = 3'd5,
    EV_CHANGED = 3'd6,
    EV_START   = 3'd7
  } event_e;

  // Buzzer patterns
  typedef enum logic [2:0] {
    BZ_OFF   = 3'd0,
    BZ_ALARM = 3'd1,
    BZ_LOW   = 3'd2,
    BZ_MID   = 3'd3,
    BZ_HIGH  = 3'd4
  } buzzer_e;

  // Item opcodes
  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  // Key codes that carry a meaning beyond the digits
  localparam logic [3:0] KeyMaxDigit = 4'd9;
  localparam logic [3:0] KeyA        = 4'd10;
  localparam logic [3:0] KeyB        = 4'd11;
  localparam logic [3:0] KeyStar     = 4'd14;
  localparam logic [3:0] KeyHash     = 4'd15;

  // Countdown length after reset, in ticks
  localparam logic [3:0] CountdownReset = 4'd9;

  // Factory code is 1, 2, 3, 4 (truncated for short code buffers)
  localparam int unsigned FactoryLen = 4;

  // One result item
  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] event_res;
    logic [2:0] buzzer;
    logic [2:0] digits_entered;
    logic [3:0] ticks_left;
  } result_t;

endpackage

@@ hw/rtl/kcal_if.sv @@
// Input item channel: one key press or one tick
interface kcal_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] key_code;

  modport source (output valid, output opcode, output key_code, input ready);
  modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

// Result item channel
interface kcal_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [2:0] event_res;
  logic [2:0] buzzer;
  logic [2:0] digits_entered;
  logic [3:0] ticks_left;

  modport source (output valid, output mode, output event_res, output buzzer,
                  output digits_entered, output ticks_left, input ready);
  modport sink   (input valid, input mode, input event_res, input buzzer,
                  input digits_entered, input ticks_left, output ready);
endinterface

// Configuration write channel: countdown length
interface kcal_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] countdown_seconds;

  modport source (output valid, output countdown_seconds, input ready);
  modport sink   (input valid, input countdown_seconds, output ready);
endinterface

@@ hw/rtl/kcal_core.sv @@
module kcal_core #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_countdown_i,
  input  logic              accept_i,
  input  logic              opcode_i,
  input  logic [3:0]        key_code_i,
  output kcal_pkg::result_t res_o
);

  localparam int unsigned CntW     = $clog2(CODE_DIGITS + 1);
  localparam int unsigned ResetLen =
    (CODE_DIGITS < kcal_pkg::FactoryLen) ? CODE_DIGITS : kcal_pkg::FactoryLen;

  kcal_pkg::mode_e mode_q, mode_d;
  logic [3:0]      countdown_cfg_q;
  logic [3:0]      left_q, left_d;
  logic [3:0]      entry_q [CODE_DIGITS];
  logic [3:0]      entry_d [CODE_DIGITS];
  logic [3:0]      code_q  [CODE_DIGITS];
  logic [3:0]      code_d  [CODE_DIGITS];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] len_q, len_d;

  kcal_pkg::event_e  ev;
  kcal_pkg::buzzer_e bz, beep;
  logic              clear_entry;
  logic              match;
  logic              buf_full;

  assign buf_full = (count_q >= CntW'(CODE_DIGITS));

  // Entry matches the stored code: same length, same digits up to that length
  always_comb begin
    match = (count_q == len_q);
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if ((CntW'(i) < len_q) && (entry_q[i] != code_q[i])) begin
        match = 1'b0;
      end
    end
  end

  // Next state and result for the item at the input
  always_comb begin
    mode_d      = mode_q;
    left_d      = left_q;
    count_d     = count_q;
    len_d       = len_q;
    entry_d     = entry_q;
    code_d      = code_q;
    ev          = kcal_pkg::EV_NONE;
    bz          = kcal_pkg::BZ_OFF;
    clear_entry = 1'b0;
    beep        = (mode_q == kcal_pkg::MODE_ARMED) ? kcal_pkg::BZ_OFF : kcal_pkg::BZ_HIGH;

    if (opcode_i == kcal_pkg::OP_TICK) begin
      if (mode_q == kcal_pkg::MODE_COUNT) begin
        if (left_q <= 4'd1) begin
          left_d      = '0;
          mode_d      = kcal_pkg::MODE_ARMED;
          clear_entry = 1'b1;
          ev          = kcal_pkg::EV_ARMED;
        end else begin
          left_d = left_q - 4'd1;
          bz     = kcal_pkg::BZ_LOW;
        end
      end
    end else begin
      unique case (mode_q) inside
        kcal_pkg::MODE_IDLE: begin
          if (key_code_i == kcal_pkg::KeyA) begin
            mode_d = kcal_pkg::MODE_COUNT;
            left_d = countdown_cfg_q;
            ev     = kcal_pkg::EV_START;
            bz     = kcal_pkg::BZ_MID;
          end else if (key_code_i == kcal_pkg::KeyB) begin
            mode_d      = kcal_pkg::MODE_VERIFY;
            clear_entry = 1'b1;
            bz          = kcal_pkg::BZ_HIGH;
          end
        end
        kcal_pkg::MODE_ARMED, kcal_pkg::MODE_VERIFY, kcal_pkg::MODE_NEW: begin
          if (key_code_i <= kcal_pkg::KeyMaxDigit) begin
            bz = beep;
            if (buf_full) begin
              clear_entry = 1'b1;
              ev          = kcal_pkg::EV_CLEAR;
            end else begin
              for (int i = 0; i < CODE_DIGITS; i++) begin
                if (CntW'(i) == count_q) begin
                  entry_d[i] = key_code_i;
                end
              end
              count_d = count_q + CntW'(1);
              ev      = kcal_pkg::EV_DIGIT;
            end
          end else if (key_code_i == kcal_pkg::KeyHash) begin
            clear_entry = 1'b1;
            ev          = kcal_pkg::EV_CLEAR;
          end else if (key_code_i == kcal_pkg::KeyStar) begin
            if (mode_q == kcal_pkg::MODE_NEW) begin
              code_d = entry_q;
              len_d  = count_q;
              mode_d = kcal_pkg::MODE_IDLE;
              ev     = kcal_pkg::EV_CHANGED;
              bz     = kcal_pkg::BZ_HIGH;
            end else if (match) begin
              mode_d = (mode_q == kcal_pkg::MODE_ARMED) ? kcal_pkg::MODE_IDLE
                                                        : kcal_pkg::MODE_NEW;
              ev     = kcal_pkg::EV_ACCEPT;
            end else begin
              ev = kcal_pkg::EV_REJECT;
            end
            clear_entry = 1'b1;
          end
        end
        default: begin
          // countdown ignores keys
        end
      endcase
    end

    if (clear_entry) begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
        entry_d[i] = '0;
      end
      count_d = '0;
    end

    // Alarm sounds in every result while armed
    if (mode_d == kcal_pkg::MODE_ARMED) begin
      bz = kcal_pkg::BZ_ALARM;
    end
  end

  // Result for the item being accepted
  always_comb begin
    res_o.mode           = mode_d;
    res_o.event_res      = ev;
    res_o.buzzer         = bz;
    res_o.digits_entered = 3'(count_d);
    res_o.ticks_left     = (mode_d == kcal_pkg::MODE_COUNT) ? left_d : 4'd0;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_cfg_q <= kcal_pkg::CountdownReset;
    end else if (cfg_we_i) begin
      countdown_cfg_q <= cfg_countdown_i;
    end
  end

  // Lock state, updated once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= kcal_pkg::MODE_IDLE;
      left_q  <= '0;
      count_q <= '0;
      len_q   <= CntW'(ResetLen);
      for (int i = 0; i < CODE_DIGITS; i++) begin
        entry_q[i] <= '0;
        code_q[i]  <= (i < kcal_pkg::FactoryLen) ? 4'(i + 1) : 4'd0;
      end
    end else if (accept_i) begin
      mode_q  <= mode_d;
      left_q  <= left_d;
      count_q <= count_d;
      len_q   <= len_d;
      entry_q <= entry_d;
      code_q  <= code_d;
    end
  end

endmodule

@@ hw/rtl/kcal_outbuf.sv @@
module kcal_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kcal_pkg::result_t res_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output kcal_pkg::result_t res_o
);

  kcal_pkg::result_t main_q, skid_q;
  logic              main_valid_q, skid_valid_q;
  logic              pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign res_o   = main_q;
  assign pop     = main_valid_q && pop_ready_i;

  // Valid flags: two-entry queue, head in main, overflow in skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= res_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_q <= res_i;
      end else begin
        main_q <= res_i;
      end
    end
  end

endmodule

@@ hw/rtl/keypad_code_alarm_lock_top.sv @@
// Keypad code lock with arming countdown. Each input item is a key press or a
// one-second tick and yields exactly one result item (mode, event, buzzer,
// digit count, ticks left). One item is accepted per clock while input ready
// is high; its result appears on the output in the cycle after acceptance
// when no earlier result waits ahead of it, from a two-entry output buffer,
// so input ready only drops when two results wait unread. The countdown
// length register may be written at any time the block is idle; its ready is
// always high. CODE_DIGITS sets the size of the entry and code buffers.
module keypad_code_alarm_lock_top #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kcal_cfg_if.sink   cfg_i,
  kcal_in_if.sink    in_i,
  kcal_out_if.source out_o
);

  kcal_pkg::result_t res_d, res_q;
  logic              accept;
  logic              in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;

  // Lock state and per-item decode
  kcal_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_i.valid),
    .cfg_countdown_i (cfg_i.countdown_seconds),
    .accept_i        (accept),
    .opcode_i        (in_i.opcode),
    .key_code_i      (in_i.key_code),
    .res_o           (res_d)
  );

  // Result register with skid entry
  kcal_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res_d),
    .ready_o     (in_ready),
    .valid_o     (out_o.valid),
    .pop_ready_i (out_o.ready),
    .res_o       (res_q)
  );

  assign out_o.mode           = res_q.mode;
  assign out_o.event_res      = res_q.event_res;
  assign out_o.buzzer         = res_q.buzzer;
  assign out_o.digits_entered = res_q.digits_entered;
  assign out_o.ticks_left     = res_q.ticks_left;

endmodule

@@ bench/tb_keypad_code_alarm_lock_top.sv @@
`timescale 1ns / 1ps

module tb_keypad_code_alarm_lock_top;

  localparam int unsigned CodeDigits = 4;
  localparam time         ClkPeriod = 8;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned HoldOffCycles = 120;
  localparam int unsigned LimitCycles = 250_000;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned DrainCycles = 4;

  // Keys without a package name
  localparam logic [3:0] KeyC = 4'd12;
  localparam logic [3:0] KeyD = 4'd13;

  typedef struct packed {
    kcal_pkg::opcode_e op;
    logic [3:0]        key;
  } key_item_t;

  // Lock state tracker and result checker
  class lock_scoreboard;
    kcal_pkg::mode_e   mode;
    logic [3:0]        entry[CodeDigits];
    int unsigned       entry_cnt;
    logic [3:0]        code[CodeDigits];
    int unsigned       code_len;
    logic [3:0]        ticks;
    logic [3:0]        countdown_len;
    kcal_pkg::result_t expected_results[$];
    int unsigned       mismatches;

    function new();
      countdown_len = kcal_pkg::CountdownReset;
      mode = kcal_pkg::MODE_IDLE;
      clear_entry();
      code_len = 0;
      foreach (code[i]) begin
        code[i] = '0;
        if (i < kcal_pkg::FactoryLen) begin
          code[i] = 4'(i + 1);
          code_len++;
        end
      end
      ticks = '0;
      mismatches = 0;
    endfunction

    function void clear_entry();
      foreach (entry[i]) entry[i] = '0;
      entry_cnt = 0;
    endfunction

    function bit entry_matches();
      if (entry_cnt != code_len) return 1'b0;
      for (int i = 0; i < code_len && i < CodeDigits; i++) begin
        if (entry[i] != code[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void set_countdown(logic [3:0] len);
      countdown_len = len;
    endfunction

    // Advance the lock by one accepted item and queue the result it yields
    function void predict_step(kcal_pkg::opcode_e op, logic [3:0] key);
      kcal_pkg::event_e  ev;
      kcal_pkg::buzzer_e bz;
      kcal_pkg::buzzer_e beep;
      kcal_pkg::result_t r;
      ev = kcal_pkg::EV_NONE;
      bz = kcal_pkg::BZ_OFF;
      if (op == kcal_pkg::OP_TICK) begin
        if (mode == kcal_pkg::MODE_COUNT) begin
          // a zero count still takes one tick to arm
          if (ticks <= 4'd1) begin
            ticks = '0;
            mode = kcal_pkg::MODE_ARMED;
            clear_entry();
            ev = kcal_pkg::EV_ARMED;
          end else begin
            ticks--;
            bz = kcal_pkg::BZ_LOW;
          end
        end
      end else if (mode == kcal_pkg::MODE_IDLE) begin
        if (key == kcal_pkg::KeyA) begin
          mode = kcal_pkg::MODE_COUNT;
          ticks = countdown_len;
          ev = kcal_pkg::EV_START;
          bz = kcal_pkg::BZ_MID;
        end else if (key == kcal_pkg::KeyB) begin
          mode = kcal_pkg::MODE_VERIFY;
          clear_entry();
          bz = kcal_pkg::BZ_HIGH;
        end
      end else if (mode != kcal_pkg::MODE_COUNT) begin
        beep = (mode == kcal_pkg::MODE_ARMED) ? kcal_pkg::BZ_OFF : kcal_pkg::BZ_HIGH;
        if (key <= kcal_pkg::KeyMaxDigit) begin
          bz = beep;
          if (entry_cnt >= CodeDigits) begin
            // full buffer: the extra digit wipes the entry
            clear_entry();
            ev = kcal_pkg::EV_CLEAR;
          end else begin
            entry[entry_cnt] = key;
            entry_cnt++;
            ev = kcal_pkg::EV_DIGIT;
          end
        end else if (key == kcal_pkg::KeyHash) begin
          clear_entry();
          ev = kcal_pkg::EV_CLEAR;
        end else if (key == kcal_pkg::KeyStar) begin
          if (mode == kcal_pkg::MODE_NEW) begin
            code = entry;
            code_len = entry_cnt;
            mode = kcal_pkg::MODE_IDLE;
            ev = kcal_pkg::EV_CHANGED;
            bz = kcal_pkg::BZ_HIGH;
          end else if (entry_matches()) begin
            mode = (mode == kcal_pkg::MODE_ARMED) ? kcal_pkg::MODE_IDLE
                                                  : kcal_pkg::MODE_NEW;
            ev = kcal_pkg::EV_ACCEPT;
          end else begin
            ev = kcal_pkg::EV_REJECT;
          end
          clear_entry();
        end
      end

      if (mode == kcal_pkg::MODE_ARMED) bz = kcal_pkg::BZ_ALARM;

      r.mode = mode;
      r.event_res = ev;
      r.buzzer = bz;
      r.digits_entered = 3'(entry_cnt);
      r.ticks_left = (mode == kcal_pkg::MODE_COUNT) ? ticks : 4'd0;
      expected_results.push_back(r);
    endfunction

    function void check_result(kcal_pkg::result_t got);
      kcal_pkg::result_t exp;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected result: mode=%0d ev=%0d bz=%0d digits=%0d ticks=%0d",
                   got.mode, got.event_res, got.buzzer, got.digits_entered, got.ticks_left);
        return;
      end
      exp = expected_results.pop_front();
      if (got.mode !== exp.mode || got.event_res !== exp.event_res ||
          got.buzzer !== exp.buzzer || got.digits_entered !== exp.digits_entered ||
          got.ticks_left !== exp.ticks_left) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("mismatch at %0t: exp mode=%0d ev=%0d bz=%0d digits=%0d ticks=%0d, %s",
                   $time, exp.mode, exp.event_res, exp.buzzer, exp.digits_entered,
                   exp.ticks_left,
                   $sformatf("got mode=%0d ev=%0d bz=%0d digits=%0d ticks=%0d",
                             got.mode, got.event_res, got.buzzer, got.digits_entered,
                             got.ticks_left));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kcal_in_if  in_if ();
  kcal_out_if out_if ();
  kcal_cfg_if cfg_if ();

  keypad_code_alarm_lock_top #(
    .CODE_DIGITS(CodeDigits)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  lock_scoreboard sb;
  key_item_t      key_plan[$];
  bit             calm = 1'b0;
  bit             hold_off_req = 1'b0;

  always #(ClkPeriod / 2) clk = ~clk;

  // Stimulus planning
  function automatic void push_item(kcal_pkg::opcode_e op, logic [3:0] key);
    key_item_t it;
    it.op = op;
    it.key = key;
    key_plan.push_back(it);
  endfunction

  function automatic void push_digits(int unsigned n);
    for (int i = 0; i < n; i++) push_item(kcal_pkg::OP_KEY, 4'($urandom_range(0, 9)));
  endfunction

  function automatic void push_noise();
    push_item(kcal_pkg::opcode_e'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
  endfunction

  // Mostly well-formed key sequences, chosen from the tracked lock mode
  function automatic void plan_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (sb.mode) inside
      kcal_pkg::MODE_IDLE: begin
        if (pick < 4) push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyA);
        else if (pick < 7) push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyB);
        else push_noise();
      end
      kcal_pkg::MODE_COUNT: begin
        if (pick < 8) push_item(kcal_pkg::OP_TICK, 4'($urandom_range(0, 15)));
        else push_noise();
      end
      kcal_pkg::MODE_ARMED, kcal_pkg::MODE_VERIFY: begin
        if (pick < 5) begin
          for (int i = 0; i < sb.code_len; i++) push_item(kcal_pkg::OP_KEY, sb.code[i]);
          push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
        end else if (pick < 7) begin
          push_digits($urandom_range(0, CodeDigits + 1));
          push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
        end else if (pick < 8) begin
          push_digits($urandom_range(1, CodeDigits));
          push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyHash);
        end else begin
          push_noise();
        end
      end
      default: begin
        if (pick < 8) begin
          push_digits($urandom_range(0, CodeDigits));
          push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
        end else if (pick < 9) begin
          push_digits($urandom_range(CodeDigits + 1, CodeDigits + 2));
          push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
        end else begin
          push_noise();
        end
      end
    endcase
  endfunction

  // Drivers; each is entered and left just after a falling edge
  task automatic drive_item(kcal_pkg::opcode_e op, logic [3:0] key);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.key_code <= key;
    do @(posedge clk); while (!in_if.ready);
    sb.predict_step(op, key);
    @(negedge clk);
  endtask

  task automatic play_plan();
    key_item_t it;
    while (key_plan.size() != 0) begin
      it = key_plan.pop_front();
      drive_item(it.op, it.key);
    end
  endtask

  task automatic run_random(int unsigned count);
    key_item_t   it;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if (key_plan.size() == 0) plan_sequence();
      it = key_plan.pop_front();
      drive_item(it.op, it.key);
      sent++;
    end
    key_plan.delete();
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_countdown(logic [3:0] len);
    cfg_if.valid <= 1'b1;
    cfg_if.countdown_seconds <= len;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_countdown(len);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Result receiver: random stalls, one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : watch_results
    kcal_pkg::result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.mode = out_if.mode;
      got.event_res = out_if.event_res;
      got.buzzer = out_if.buzzer;
      got.digits_entered = out_if.digits_entered;
      got.ticks_left = out_if.ticks_left;
      sb.check_result(got);
    end
  end

  // Main sequence
  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = kcal_pkg::OP_KEY;
    in_if.key_code = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.countdown_seconds = kcal_pkg::CountdownReset;
    sb = new();
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Shortest countdown: idle oddities, arming, buffer overflow, disarm
    write_countdown(4'd1);
    push_item(kcal_pkg::OP_TICK, kcal_pkg::KeyHash);
    push_item(kcal_pkg::OP_KEY, KeyC);
    push_item(kcal_pkg::OP_KEY, KeyD);
    push_item(kcal_pkg::OP_KEY, 4'd0);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyHash);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyA);
    push_item(kcal_pkg::OP_KEY, 4'd7);
    push_item(kcal_pkg::OP_TICK, 4'd0);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyA);
    push_item(kcal_pkg::OP_KEY, 4'd9);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyHash);
    push_item(kcal_pkg::OP_KEY, 4'd1);
    push_item(kcal_pkg::OP_KEY, 4'd2);
    push_item(kcal_pkg::OP_KEY, 4'd3);
    push_item(kcal_pkg::OP_KEY, 4'd4);
    push_item(kcal_pkg::OP_KEY, 4'd0);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
    push_item(kcal_pkg::OP_KEY, 4'd1);
    push_item(kcal_pkg::OP_KEY, 4'd2);
    push_item(kcal_pkg::OP_KEY, 4'd3);
    push_item(kcal_pkg::OP_KEY, 4'd4);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
    play_plan();
    wait_drained();

    // Longest countdown; change the code to an empty one, then random traffic
    write_countdown(4'd15);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyB);
    push_item(kcal_pkg::OP_KEY, 4'd1);
    push_item(kcal_pkg::OP_KEY, 4'd2);
    push_item(kcal_pkg::OP_KEY, 4'd3);
    push_item(kcal_pkg::OP_KEY, 4'd4);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
    push_item(kcal_pkg::OP_KEY, kcal_pkg::KeyStar);
    play_plan();
    hold_off_req = 1'b1;
    run_random(90);
    wait_drained();

    write_countdown(4'($urandom_range(1, 15)));
    run_random(90);
    wait_drained();

    write_countdown(4'd2);
    run_random(90);
    wait_drained();

    write_countdown(4'($urandom_range(1, 15)));
    run_random(90);
    wait_drained();

    // Closing stretch at full rate on both sides
    calm = 1'b1;
    write_countdown(4'($urandom_range(1, 15)));
    run_random(90);
    wait_drained();

    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("== FAIL ==");
    $finish;
  end

endmodule
